### hdl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define RTNC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be seen outside reset.
`define RTNC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/rtnc_pkg.sv
package rtnc_pkg;

  localparam int KW = 12;
  localparam int LW = 10;

  typedef logic signed [KW-1:0] pos_t;
  typedef logic [LW-1:0]        len_t;
  typedef logic signed [7:0]    plen_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_I,
    S_LD_I,
    S_PROBE,
    S_EVAL,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_DP,
    PH_DM,
    PH_GROW,
    PH_SRCH,
    PH_DNODE,
    PH_SPLIT
  } phase_t;

  function automatic logic [5:0] clz32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int b = 0; b < 32; b++) begin
      if (v[b]) begin
        n = 6'(31 - b);
      end
    end
    return n;
  endfunction

endpackage

### hdl/rtnc_ram.sv
module rtnc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/rtnc_prefix.sv
module rtnc_prefix
  import rtnc_pkg::*;
(
  input  logic [31:0] code_i,
  input  logic [31:0] code_k,
  input  logic [8:0]  idx_i,
  input  logic [8:0]  idx_k,
  input  logic        oor,
  output plen_t       plen
);

  logic       eq;
  logic [6:0] len;

  assign eq = (code_i == code_k);

  always_comb begin
    if (eq) begin
      len = 7'd32 + 7'(clz32({23'b0, idx_i ^ idx_k}));
    end else begin
      len = 7'(clz32(code_i ^ code_k));
    end
    if (oor) begin
      plen = -8'sd1;
    end else begin
      plen = signed'({1'b0, len});
    end
  end

endmodule

### hdl/radix_tree_node_children.sv
// Write item: the code is stored at the clock edge of acceptance if its slot is below MAX_LEAVES.
// Query for an invalid node: the sequencer goes straight to S_DONE, then the result is registered out.
// Valid query: the code of node i is read (S_RD_I, S_LD_I); P in-range probes (S_PROBE,
// then S_EVAL) and Q out-of-range probes (S_PROBE only); P + Q <= 27 with 256 leaves.
// One item at a time; cycles that out_tready holds a result back delay the next item.
// Reset clears the sequencer and the output valid and sets leaf_count to 256, not the table.
`include "assert_macros.svh"

module radix_tree_node_children
  import rtnc_pkg::*;
#(
  parameter int MAX_LEAVES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // slot [7:0], code_value [39:8], node [47:40]
  input  logic [47:0] in_tdata,
  // kind
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // left_child [7:0], left_is_leaf [8], right_child [16:9], right_is_leaf [17], zeros
  output logic [23:0] out_tdata,
  // invalid
  output logic        out_tuser
);

  localparam int AW = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;

  state_t      state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic [8:0]  leaf_count_r;
  logic [8:0]  n_r, n_nxt;
  logic [7:0]  i_r, i_nxt;
  logic [31:0] ci_r, ci_nxt;
  pos_t        k_r, k_nxt;
  pos_t        j_r, j_nxt;
  plen_t       dp_r, dp_nxt;
  plen_t       dmin_r, dmin_nxt;
  plen_t       dnode_r, dnode_nxt;
  logic        dneg_r, dneg_nxt;
  len_t        lmax_r, lmax_nxt;
  len_t        l_r, l_nxt;
  len_t        t_r, t_nxt;
  len_t        s_r, s_nxt;
  logic [23:0] res_data_r, res_data_nxt;
  logic        res_user_r, res_user_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r;
  logic        out_user_r;

  logic        in_acc;
  logic        in_kind;
  logic [7:0]  in_slot;
  logic [31:0] in_code;
  logic [7:0]  in_node;
  logic [8:0]  n_in;
  logic        node_bad;
  logic        k_oor;
  logic        consume;
  logic        finish;
  logic        out_load;
  plen_t       plen;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0] ram_rdata;

  logic        neg_sel;
  len_t        off_sel;
  pos_t        ib;

  assign in_kind = in_tuser;
  assign in_slot = in_tdata[7:0];
  assign in_code = in_tdata[39:8];
  assign in_node = in_tdata[47:40];

  assign in_tready = (state_r == S_IDLE) && rst_n;
  assign in_acc    = in_tvalid && in_tready;
  assign n_in      = (32'(leaf_count_r) > MAX_LEAVES) ? 9'(MAX_LEAVES) : leaf_count_r;
  assign node_bad  = ({1'b0, in_node} + 9'd1) >= n_in;
  assign k_oor     = (k_r < 0) || (k_r >= signed'({3'b0, n_r}));
  assign consume   = ((state_r == S_PROBE) && k_oor) || (state_r == S_EVAL);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign ib        = signed'({4'b0, i_r});

  assign ram_we = in_acc && !in_kind && (32'(in_slot) < MAX_LEAVES);

  always_comb begin
    unique case (state_r)
      S_IDLE:  ram_addr = AW'(in_slot);
      S_RD_I:  ram_addr = AW'(i_r);
      default: ram_addr = AW'(unsigned'(k_r));
    endcase
  end

  rtnc_ram #(
    .WIDTH(32),
    .DEPTH(MAX_LEAVES)
  ) u_code_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_code),
    .rdata(ram_rdata)
  );

  rtnc_prefix u_prefix (
    .code_i(ci_r),
    .code_k(ram_rdata),
    .idx_i ({1'b0, i_r}),
    .idx_k (k_r[8:0]),
    .oor   (k_oor),
    .plen  (plen)
  );

  // Search datapath: captures a query, loads the code of node i and folds in one probe result per consume cycle.
  always_comb begin
    logic       gt_min;
    logic       gt_node;
    logic       dneg_new;
    len_t       l_new;
    len_t       s_new;
    len_t       t_new;
    pos_t       g;
    pos_t       lo;
    pos_t       hi;
    phase_nxt    = phase_r;
    n_nxt        = n_r;
    i_nxt        = i_r;
    ci_nxt       = ci_r;
    k_nxt        = k_r;
    j_nxt        = j_r;
    dp_nxt       = dp_r;
    dmin_nxt     = dmin_r;
    dnode_nxt    = dnode_r;
    dneg_nxt     = dneg_r;
    lmax_nxt     = lmax_r;
    l_nxt        = l_r;
    t_nxt        = t_r;
    s_nxt        = s_r;
    res_data_nxt = res_data_r;
    res_user_nxt = res_user_r;
    finish       = 1'b0;
    neg_sel      = dneg_r;
    off_sel      = '0;
    gt_min       = plen > dmin_r;
    gt_node      = plen > dnode_r;
    dneg_new     = dp_r < plen;
    l_new        = gt_min ? len_t'(l_r + t_r) : l_r;
    s_new        = gt_node ? len_t'(s_r + t_r) : s_r;
    t_new        = len_t'((t_r + 1'b1) >> 1);
    g            = '0;
    lo           = '0;
    hi           = '0;

    if (in_acc && in_kind) begin
      n_nxt = n_in;
      i_nxt = in_node;
      if (node_bad) begin
        res_data_nxt = '0;
        res_user_nxt = 1'b1;
      end
    end

    if (state_r == S_LD_I) begin
      ci_nxt    = ram_rdata;
      phase_nxt = PH_DP;
      neg_sel   = 1'b0;
      off_sel   = len_t'(1);
      k_nxt     = ib + signed'({2'b0, off_sel});
    end

    if (consume) begin
      unique case (phase_r)
        PH_DP: begin
          dp_nxt    = plen;
          neg_sel   = 1'b1;
          off_sel   = len_t'(1);
          phase_nxt = PH_DM;
        end
        PH_DM: begin
          dneg_nxt  = dneg_new;
          dmin_nxt  = dneg_new ? dp_r : plen;
          lmax_nxt  = len_t'(2);
          neg_sel   = dneg_new;
          off_sel   = len_t'(2);
          phase_nxt = PH_GROW;
        end
        PH_GROW: begin
          if (gt_min) begin
            lmax_nxt = lmax_r << 1;
            off_sel  = lmax_r << 1;
          end else begin
            t_new     = len_t'((lmax_r + 1'b1) >> 1);
            l_nxt     = '0;
            t_nxt     = t_new;
            off_sel   = t_new;
            phase_nxt = PH_SRCH;
          end
        end
        PH_SRCH: begin
          l_nxt = l_new;
          if (t_r > len_t'(1)) begin
            t_nxt   = t_new;
            off_sel = len_t'(l_new + t_new);
          end else begin
            off_sel   = l_new;
            phase_nxt = PH_DNODE;
          end
        end
        PH_DNODE: begin
          dnode_nxt = plen;
          j_nxt     = k_r;
          s_nxt     = '0;
          t_new     = len_t'((l_r + 1'b1) >> 1);
          t_nxt     = t_new;
          off_sel   = t_new;
          phase_nxt = PH_SPLIT;
        end
        PH_SPLIT: begin
          s_nxt = s_new;
          if (t_r > len_t'(1)) begin
            t_nxt   = t_new;
            off_sel = len_t'(s_new + t_new);
          end else begin
            off_sel = len_t'(s_new + len_t'(dneg_r));
            finish  = 1'b1;
          end
        end
        default: begin
          off_sel = '0;
        end
      endcase
      if (neg_sel) begin
        k_nxt = ib - signed'({2'b0, off_sel});
      end else begin
        k_nxt = ib + signed'({2'b0, off_sel});
      end
      if (phase_r == PH_SRCH && phase_nxt == PH_DNODE) begin
        j_nxt = k_nxt;
      end
      if (finish) begin
        g  = k_nxt;
        lo = dneg_r ? j_r : ib;
        hi = dneg_r ? ib : j_r;
        res_data_nxt = {6'b0, (hi == g + 1'b1), 8'(g + 1'b1), (lo == g), g[7:0]};
        res_user_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_kind) begin
          state_nxt = node_bad ? S_DONE : S_RD_I;
        end
      end
      S_RD_I: state_nxt = S_LD_I;
      S_LD_I: state_nxt = S_PROBE;
      S_PROBE: begin
        if (k_oor) begin
          state_nxt = finish ? S_DONE : S_PROBE;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: state_nxt = finish ? S_DONE : S_PROBE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_DP;
      leaf_count_r <= 9'd256;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        leaf_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    ci_r       <= ci_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    dp_r       <= dp_nxt;
    dmin_r     <= dmin_nxt;
    dnode_r    <= dnode_nxt;
    dneg_r     <= dneg_nxt;
    lmax_r     <= lmax_nxt;
    l_r        <= l_nxt;
    t_r        <= t_nxt;
    s_r        <= s_nxt;
    res_data_r <= res_data_nxt;
    res_user_r <= res_user_nxt;
    if (out_load) begin
      out_data_r <= res_data_r;
      out_user_r <= res_user_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `RTNC_ASSERT(a_query_busy, (in_acc && in_kind) |=> (state_r != S_IDLE), "query not started")
  `RTNC_ASSERT(a_write_idle, (in_acc && !in_kind) |=> (state_r == S_IDLE), "write left idle")
  `RTNC_ASSERT(a_eval_after_probe, (state_r == S_EVAL) |-> ($past(state_r) == S_PROBE),
    "evaluation without a read")
  `RTNC_NEVER(a_rose_outside_done, $rose(out_valid_r) && ($past(state_r) != S_DONE),
    "result raised outside completion")

endmodule
